// ===== rtl/psg_pkg.sv =====
// shared constants, codes and helpers of the sound generator
package psg_pkg;

  localparam int unsigned NumRegs    = 16;
  localparam int unsigned RegAddrW   = 4;
  localparam int unsigned DataW      = 8;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned NumChan    = 3;
  localparam int unsigned LevelW     = 5;
  localparam int unsigned SumW       = 7;
  localparam int unsigned ToneCntW   = 12;
  localparam int unsigned ToneDivW   = 3;
  localparam int unsigned NoiseCntW  = 5;
  localparam int unsigned NoiseDivW  = 4;
  localparam int unsigned NoiseLfsrW = 17;
  localparam int unsigned NoiseTapB  = 3;
  localparam int unsigned EnvCntW    = 16;
  localparam int unsigned EnvDivW    = 8;
  localparam int unsigned EnvPosW    = 5;

  typedef enum logic [ModeW-1:0] {
    ModeTick  = 2'd0,
    ModeLatch = 2'd1,
    ModeWrite = 2'd2,
    ModeRead  = 2'd3
  } mode_e;

  // register addresses
  localparam logic [RegAddrW-1:0] RegToneACoarse = 4'd1;
  localparam logic [RegAddrW-1:0] RegToneBCoarse = 4'd3;
  localparam logic [RegAddrW-1:0] RegToneCCoarse = 4'd5;
  localparam logic [RegAddrW-1:0] RegNoisePeriod = 4'd6;
  localparam logic [RegAddrW-1:0] RegMixer       = 4'd7;
  localparam logic [RegAddrW-1:0] RegAmpA        = 4'd8;
  localparam logic [RegAddrW-1:0] RegAmpB        = 4'd9;
  localparam logic [RegAddrW-1:0] RegAmpC        = 4'd10;
  localparam logic [RegAddrW-1:0] RegEnvPerLo    = 4'd11;
  localparam logic [RegAddrW-1:0] RegEnvPerHi    = 4'd12;
  localparam logic [RegAddrW-1:0] RegEnvShape    = 4'd13;
  localparam logic [RegAddrW-1:0] RegPortA       = 4'd14;
  localparam logic [RegAddrW-1:0] RegPortB       = 4'd15;

  // bit positions
  localparam int unsigned MixNoiseOff  = 3;
  localparam int unsigned MixPortAOut  = 6;
  localparam int unsigned MixPortBOut  = 7;
  localparam int unsigned ShapeHold    = 0;
  localparam int unsigned ShapeAlt     = 1;
  localparam int unsigned ShapeAttack  = 2;
  localparam int unsigned ShapeCont    = 3;
  localparam int unsigned AmpEnvSel    = 4;

  localparam logic [EnvPosW-1:0] EnvMax   = 5'd31;
  localparam logic [DataW-1:0]   PortBIdle = 8'hFF;

  // bits kept by a register write
  function automatic logic [DataW-1:0] write_mask(input logic [RegAddrW-1:0] addr);
    logic [DataW-1:0] m;
    unique case (addr)
      RegToneACoarse, RegToneBCoarse, RegToneCCoarse, RegEnvShape: m = 8'h0F;
      RegNoisePeriod, RegAmpA, RegAmpB, RegAmpC:                   m = 8'h1F;
      default:                                                     m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/psg_in_if.sv =====
// input channel: bus or tick beat with keyboard and external lines
interface psg_in_if;
  import psg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ModeW-1:0]     mode;
  logic [DataW-1:0]     data;
  logic [DataW-1:0]     key_columns;
  logic [DataW-1:0]     ext_lines;

  modport source (output valid, mode, data, key_columns, ext_lines, input ready);
  modport sink   (input valid, mode, data, key_columns, ext_lines, output ready);
endinterface

// ===== rtl/psg_out_if.sv =====
// output channel: read value and channel levels
interface psg_out_if;
  import psg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DataW-1:0]     read_data;
  logic [LevelW-1:0]    level_a;
  logic [LevelW-1:0]    level_b;
  logic [LevelW-1:0]    level_c;
  logic [SumW-1:0]      level_sum;

  modport source (output valid, read_data, level_a, level_b, level_c, level_sum,
                  input ready);
  modport sink   (input valid, read_data, level_a, level_b, level_c, level_sum,
                  output ready);
endinterface

// ===== rtl/psg_tone_noise_envelope_top.sv =====
// three-channel tone, noise and envelope sound generator with register file
// an accepted input beat's result is registered in the output register in the next cycle
// throughput: one beat per cycle unless the output stalls; the generator update for a tick
//   fits between the state and output registers, so beats may follow back to back
// reset (rst_ni low, asynchronous): register file, counters and levels clear,
//   the noise shift register loads one, the output register goes empty
module psg_tone_noise_envelope_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  psg_in_if.sink     in_i,
  psg_out_if.source  out_o
);
  import psg_pkg::*;

  // ---------------------------------------------------------------------------
  // handshake: the output register accepts a new beat when empty or being drained
  // ---------------------------------------------------------------------------
  logic  out_valid_q;
  logic  accept;
  logic  tick;
  logic  wr_en;
  mode_e in_mode;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign in_mode    = mode_e'(in_i.mode);
  assign tick       = accept && (in_mode == ModeTick);
  assign wr_en      = accept && (in_mode == ModeWrite);

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  logic [NumRegs-1:0][DataW-1:0]     regs_q, regs_d;
  logic [RegAddrW-1:0]               sel_q, sel_d;

  logic [ToneDivW-1:0]               tone_pre_q, tone_pre_d;
  logic [NumChan-1:0][ToneCntW-1:0]  tone_ctr_q, tone_ctr_d;
  logic [NumChan-1:0]                tone_lvl_q, tone_lvl_d;

  logic [NoiseDivW-1:0]              noise_pre_q, noise_pre_d;
  logic [NoiseCntW-1:0]              noise_ctr_q, noise_ctr_d;
  logic [NoiseLfsrW-1:0]             noise_sr_q, noise_sr_d;
  logic                              noise_bit_q, noise_bit_d;

  logic [EnvDivW-1:0]                env_div_q, env_div_d;
  logic [EnvCntW-1:0]                env_cnt_q, env_cnt_d;
  logic [EnvPosW-1:0]                env_pos_q, env_pos_d;
  logic [LevelW-1:0]                 env_amp_q, env_amp_d;
  logic                              env_rise_q, env_rise_d;
  logic                              env_frz_q, env_frz_d;

  logic [NumChan-1:0][LevelW-1:0]    chan_lvl_q, chan_lvl_d;

  // output register
  logic [DataW-1:0]                  out_rd_q;
  logic [NumChan-1:0][LevelW-1:0]    out_lvl_q;
  logic [SumW-1:0]                   out_sum_q;

  // ---------------------------------------------------------------------------
  // bus side: address latch, masked write, read mux
  // ---------------------------------------------------------------------------
  logic [DataW-1:0] wr_val;
  logic [DataW-1:0] rd_val;

  assign wr_val = in_i.data & write_mask(sel_q);

  always_comb begin
    regs_d = regs_q;
    sel_d  = sel_q;
    if (accept && (in_mode == ModeLatch)) begin
      sel_d = in_i.data[RegAddrW-1:0];   // high nibble ignored
    end
    if (wr_en) begin
      regs_d[sel_q] = wr_val;
    end
  end

  // port A in input mode sees the key matrix wired-ANDed with the connector,
  // port B in input mode floats high
  always_comb begin
    if (sel_q == RegPortA && !regs_q[RegMixer][MixPortAOut]) begin
      rd_val = in_i.key_columns & in_i.ext_lines;
    end else if (sel_q == RegPortB && !regs_q[RegMixer][MixPortBOut]) begin
      rd_val = PortBIdle;
    end else begin
      rd_val = regs_q[sel_q];
    end
  end

  // ---------------------------------------------------------------------------
  // tone generators: divide by 8, then a 12-bit period counter per channel
  // ---------------------------------------------------------------------------
  logic [NumChan-1:0][ToneCntW-1:0] tone_per;
  logic [NumChan-1:0][ToneCntW:0]   tone_next;

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      tone_per[ch] = {regs_q[RegAddrW'(2*ch+1)][3:0], regs_q[RegAddrW'(2*ch)]};
      if (tone_per[ch] == '0) begin
        tone_per[ch] = ToneCntW'(1);     // zero period behaves as one
      end
      tone_next[ch] = {1'b0, tone_ctr_q[ch]} + (ToneCntW+1)'(1);
    end
  end

  always_comb begin
    tone_pre_d = tone_pre_q;
    tone_ctr_d = tone_ctr_q;
    tone_lvl_d = tone_lvl_q;
    if (tick) begin
      if (tone_pre_q != '1) begin
        tone_pre_d = tone_pre_q + 1'b1;
      end else begin
        tone_pre_d = '0;
        for (int ch = 0; ch < NumChan; ch++) begin
          // >= so a lowered period expires right away
          if (tone_next[ch] >= {1'b0, tone_per[ch]}) begin
            tone_ctr_d[ch] = '0;
            tone_lvl_d[ch] = !tone_lvl_q[ch];
          end else begin
            tone_ctr_d[ch] = tone_next[ch][ToneCntW-1:0];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // noise: divide by 16, 5-bit period, 17-bit lfsr with taps at bits 0 and 3
  // ---------------------------------------------------------------------------
  logic [NoiseCntW-1:0] noise_period;
  logic [NoiseCntW:0]   noise_next;
  logic                 noise_fb;

  always_comb begin
    noise_period = regs_q[RegNoisePeriod][NoiseCntW-1:0];
    if (noise_period == '0) begin
      noise_period = NoiseCntW'(1);
    end
  end

  assign noise_next = {1'b0, noise_ctr_q} + (NoiseCntW+1)'(1);
  assign noise_fb   = noise_sr_q[0] ^ noise_sr_q[NoiseTapB];

  always_comb begin
    noise_pre_d = noise_pre_q;
    noise_ctr_d = noise_ctr_q;
    noise_sr_d  = noise_sr_q;
    noise_bit_d = noise_bit_q;
    if (tick) begin
      if (noise_pre_q != '1) begin
        noise_pre_d = noise_pre_q + 1'b1;
      end else begin
        noise_pre_d = '0;
        if (noise_next < {1'b0, noise_period}) begin
          noise_ctr_d = noise_next[NoiseCntW-1:0];
        end else begin
          noise_ctr_d = '0;
          noise_sr_d  = {noise_fb, noise_sr_q[NoiseLfsrW-1:1]};
          noise_bit_d = noise_sr_q[1];   // bit 0 after the shift
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // envelope: divide by 256, 16-bit period, 32-step ramp with ten shapes
  // a write to the shape register restarts the ramp
  // ---------------------------------------------------------------------------
  logic [EnvCntW-1:0]   env_per;
  logic [EnvCntW:0]     env_next;
  logic [EnvPosW-1:0]   env_pos_inc;
  logic [DataW-1:0]     env_shape;
  logic                 env_rise_flip;

  always_comb begin
    env_per = {regs_q[RegEnvPerHi], regs_q[RegEnvPerLo]};
    if (env_per == '0) begin
      env_per = EnvCntW'(1);
    end
  end

  assign env_next      = {1'b0, env_cnt_q} + (EnvCntW+1)'(1);
  assign env_pos_inc   = env_pos_q + 1'b1;
  assign env_shape     = regs_q[RegEnvShape];
  assign env_rise_flip = env_rise_q ^ env_shape[ShapeAlt];

  always_comb begin
    env_div_d  = env_div_q;
    env_cnt_d  = env_cnt_q;
    env_pos_d  = env_pos_q;
    env_amp_d  = env_amp_q;
    env_rise_d = env_rise_q;
    env_frz_d  = env_frz_q;
    if (wr_en && sel_q == RegEnvShape) begin
      env_frz_d  = 1'b0;
      env_pos_d  = '0;
      env_rise_d = wr_val[ShapeAttack];
      env_amp_d  = wr_val[ShapeAttack] ? '0 : EnvMax;
    end else if (tick) begin
      if (env_div_q != '1) begin
        env_div_d = env_div_q + 1'b1;
      end else begin
        env_div_d = '0;
        if (env_next < {1'b0, env_per}) begin
          env_cnt_d = env_next[EnvCntW-1:0];
        end else begin
          env_cnt_d = '0;
          if (!env_frz_q) begin
            if (env_pos_q != EnvMax) begin
              env_pos_d = env_pos_inc;
              env_amp_d = env_rise_q ? env_pos_inc : (EnvMax - env_pos_inc);
            end else begin
              env_pos_d = '0;
              if (!env_shape[ShapeCont]) begin
                // one-shot shapes drop to silence
                env_frz_d = 1'b1;
                env_amp_d = '0;
              end else if (env_shape[ShapeHold]) begin
                // hold at the end level, mirrored when alternating
                env_frz_d = 1'b1;
                env_amp_d = env_rise_flip ? EnvMax : '0;
              end else begin
                // repeat, reversing direction when alternating
                env_rise_d = env_rise_flip;
                env_amp_d  = env_rise_flip ? '0 : EnvMax;
              end
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // mixer: gate tone and noise per channel, pick fixed or envelope amplitude
  // uses the generator values of this same tick
  // ---------------------------------------------------------------------------
  logic [NumChan-1:0] chan_on;

  always_comb begin
    chan_lvl_d = chan_lvl_q;
    for (int ch = 0; ch < NumChan; ch++) begin
      chan_on[ch] = (tone_lvl_d[ch] || regs_q[RegMixer][ch])
                 && (noise_bit_d || regs_q[RegMixer][ch+MixNoiseOff]);
      if (tick) begin
        if (!chan_on[ch]) begin
          chan_lvl_d[ch] = '0;
        end else if (regs_q[RegAmpA + RegAddrW'(ch)][AmpEnvSel]) begin
          chan_lvl_d[ch] = env_amp_d;
        end else begin
          chan_lvl_d[ch] = {regs_q[RegAmpA + RegAddrW'(ch)][3:0], 1'b1};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q      <= '0;
      sel_q       <= '0;
      tone_pre_q  <= '0;
      tone_ctr_q  <= '0;
      tone_lvl_q  <= '0;
      noise_pre_q <= '0;
      noise_ctr_q <= '0;
      noise_sr_q  <= NoiseLfsrW'(1);
      noise_bit_q <= 1'b0;
      env_div_q   <= '0;
      env_cnt_q   <= '0;
      env_pos_q   <= '0;
      env_amp_q   <= '0;
      env_rise_q  <= 1'b0;
      env_frz_q   <= 1'b0;
      chan_lvl_q  <= '0;
    end else begin
      regs_q      <= regs_d;
      sel_q       <= sel_d;
      tone_pre_q  <= tone_pre_d;
      tone_ctr_q  <= tone_ctr_d;
      tone_lvl_q  <= tone_lvl_d;
      noise_pre_q <= noise_pre_d;
      noise_ctr_q <= noise_ctr_d;
      noise_sr_q  <= noise_sr_d;
      noise_bit_q <= noise_bit_d;
      env_div_q   <= env_div_d;
      env_cnt_q   <= env_cnt_d;
      env_pos_q   <= env_pos_d;
      env_amp_q   <= env_amp_d;
      env_rise_q  <= env_rise_d;
      env_frz_q   <= env_frz_d;
      chan_lvl_q  <= chan_lvl_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_rd_q  <= (in_mode == ModeRead) ? rd_val : '0;
      out_lvl_q <= chan_lvl_d;
      out_sum_q <= SumW'(chan_lvl_d[0]) + SumW'(chan_lvl_d[1]) + SumW'(chan_lvl_d[2]);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_rd_q;
  assign out_o.level_a   = out_lvl_q[0];
  assign out_o.level_b   = out_lvl_q[1];
  assign out_o.level_c   = out_lvl_q[2];
  assign out_o.level_sum = out_sum_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_levels_hold_off_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_mode != ModeTick |=> chan_lvl_q == $past(chan_lvl_q))
    else $error("channel levels changed on a non-tick beat");

  a_result_tracks_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q && out_lvl_q == chan_lvl_q)
    else $error("result beat does not show the current channel levels");

  a_read_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_mode != ModeRead |=> out_rd_q == '0)
    else $error("read data nonzero on a non-read beat");

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_sr_q != '0)
    else $error("noise shift register locked at zero");

  a_frozen_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_frz_q |-> env_pos_q == '0)
    else $error("frozen envelope with nonzero position");

endmodule

// ===== tb/sv/psg_level_checker.sv =====
// checker for the sound generator: predicts each result beat and compares it field by field
module psg_level_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  psg_in_if           in_mon_i,
  psg_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import psg_pkg::*;

  typedef struct packed {
    logic [DataW-1:0]  read_data;
    logic [LevelW-1:0] level_a;
    logic [LevelW-1:0] level_b;
    logic [LevelW-1:0] level_c;
    logic [SumW-1:0]   level_sum;
  } psg_beat_t;

  // bits kept on a register write, register 15 in the top byte down to register 0
  localparam logic [NumRegs*DataW-1:0] KeptBits = {
    8'hFF, 8'hFF, 8'h0F, 8'hFF, 8'hFF, 8'h1F, 8'h1F, 8'h1F,
    8'hFF, 8'h1F, 8'h0F, 8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'hFF
  };

  logic [DataW-1:0]      sound_regs [NumRegs];
  logic [RegAddrW-1:0]   addr_latch;
  logic [ToneDivW-1:0]   tone_pre;
  logic [ToneCntW-1:0]   tone_ctr [NumChan];
  logic [NumChan-1:0]    tone_sq;
  logic [NoiseDivW-1:0]  noise_pre;
  logic [NoiseCntW-1:0]  noise_ctr;
  logic [NoiseLfsrW-1:0] lfsr;
  logic                  noise_lvl;
  logic [EnvDivW-1:0]    env_div;
  logic [EnvCntW-1:0]    env_cnt;
  logic [EnvPosW-1:0]    env_pos;
  logic [LevelW-1:0]     env_amp;
  logic                  env_up;
  logic                  env_hold;
  logic [LevelW-1:0]     chan_amp [NumChan];

  psg_beat_t   expected_levels_q [$];
  int unsigned mismatches;

  task automatic step_envelope();
    logic [DataW-1:0] shape;
    shape = sound_regs[RegEnvShape];
    if (!env_hold) begin
      if (env_pos != EnvMax) begin
        env_pos = env_pos + 1'b1;
        env_amp = env_up ? env_pos : EnvMax - env_pos;
      end else begin
        env_pos = '0;
        if (!shape[ShapeCont]) begin
          env_hold = 1'b1;
          env_amp  = '0;
        end else if (shape[ShapeHold]) begin
          // hold at the far end of the ramp, or back at its start when alternating
          env_hold = 1'b1;
          env_amp  = (env_up ^ shape[ShapeAlt]) ? EnvMax : '0;
        end else begin
          if (shape[ShapeAlt]) env_up = !env_up;
          env_amp = env_up ? '0 : EnvMax;
        end
      end
    end
  endtask

  task automatic advance_sound(input mode_e m, input logic [DataW-1:0] d,
                               input logic [DataW-1:0] cols, input logic [DataW-1:0] ext,
                               output psg_beat_t r);
    logic [ToneCntW-1:0]  tper;
    logic [ToneCntW:0]    tnext;
    logic [NoiseCntW-1:0] nper;
    logic [NoiseCntW:0]   nnext;
    logic [EnvCntW-1:0]   eper;
    logic [EnvCntW:0]     enext;
    logic                 fb;
    logic                 on;
    logic [DataW-1:0]     amp;
    r = '0;
    case (m)
      ModeTick: begin
        if (tone_pre != '1) begin
          tone_pre = tone_pre + 1'b1;
        end else begin
          tone_pre = '0;
          for (int ch = 0; ch < NumChan; ch++) begin
            tper  = {sound_regs[2*ch+1][3:0], sound_regs[2*ch]};
            if (tper == '0) tper = ToneCntW'(1);
            tnext = {1'b0, tone_ctr[ch]} + (ToneCntW+1)'(1);
            if (tnext >= {1'b0, tper}) begin
              tone_ctr[ch] = '0;
              tone_sq[ch]  = !tone_sq[ch];
            end else begin
              tone_ctr[ch] = tnext[ToneCntW-1:0];
            end
          end
        end
        if (noise_pre != '1) begin
          noise_pre = noise_pre + 1'b1;
        end else begin
          noise_pre = '0;
          nper = sound_regs[RegNoisePeriod][NoiseCntW-1:0];
          if (nper == '0) nper = NoiseCntW'(1);
          nnext = {1'b0, noise_ctr} + (NoiseCntW+1)'(1);
          if (nnext < {1'b0, nper}) begin
            noise_ctr = nnext[NoiseCntW-1:0];
          end else begin
            noise_ctr = '0;
            fb        = lfsr[0] ^ lfsr[NoiseTapB];
            lfsr      = {fb, lfsr[NoiseLfsrW-1:1]};
            noise_lvl = lfsr[0];
          end
        end
        if (env_div != '1) begin
          env_div = env_div + 1'b1;
        end else begin
          env_div = '0;
          eper = {sound_regs[RegEnvPerHi], sound_regs[RegEnvPerLo]};
          if (eper == '0) eper = EnvCntW'(1);
          enext = {1'b0, env_cnt} + (EnvCntW+1)'(1);
          if (enext < {1'b0, eper}) begin
            env_cnt = enext[EnvCntW-1:0];
          end else begin
            env_cnt = '0;
            step_envelope();
          end
        end
        for (int ch = 0; ch < NumChan; ch++) begin
          on  = (tone_sq[ch] | sound_regs[RegMixer][ch]) &
                (noise_lvl | sound_regs[RegMixer][MixNoiseOff+ch]);
          amp = sound_regs[RegAmpA + ch];
          if (!on)                 chan_amp[ch] = '0;
          else if (amp[AmpEnvSel]) chan_amp[ch] = env_amp;
          else                     chan_amp[ch] = {amp[3:0], 1'b1};
        end
      end
      ModeLatch: addr_latch = d[RegAddrW-1:0];
      ModeWrite: begin
        sound_regs[addr_latch] = d & KeptBits[addr_latch*DataW +: DataW];
        if (addr_latch == RegEnvShape) begin
          env_hold = 1'b0;
          env_pos  = '0;
          env_up   = sound_regs[RegEnvShape][ShapeAttack];
          env_amp  = env_up ? '0 : EnvMax;
        end
      end
      default: begin
        if (addr_latch == RegPortA && !sound_regs[RegMixer][MixPortAOut])
          r.read_data = cols & ext;
        else if (addr_latch == RegPortB && !sound_regs[RegMixer][MixPortBOut])
          r.read_data = PortBIdle;
        else
          r.read_data = sound_regs[addr_latch];
      end
    endcase
    r.level_a   = chan_amp[0];
    r.level_b   = chan_amp[1];
    r.level_c   = chan_amp[2];
    r.level_sum = SumW'(chan_amp[0]) + SumW'(chan_amp[1]) + SumW'(chan_amp[2]);
  endtask

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    psg_beat_t want;
    psg_beat_t got;
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) sound_regs[i] = '0;
      for (int ch = 0; ch < NumChan; ch++) begin
        tone_ctr[ch] = '0;
        chan_amp[ch] = '0;
      end
      addr_latch = '0;
      tone_pre   = '0;
      tone_sq    = '0;
      noise_pre  = '0;
      noise_ctr  = '0;
      lfsr       = NoiseLfsrW'(1);
      noise_lvl  = 1'b0;
      env_div    = '0;
      env_cnt    = '0;
      env_pos    = '0;
      env_amp    = '0;
      env_up     = 1'b0;
      env_hold   = 1'b0;
      mismatches = 0;
      expected_levels_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        advance_sound(mode_e'(in_mon_i.mode), in_mon_i.data, in_mon_i.key_columns,
                      in_mon_i.ext_lines, want);
        expected_levels_q.push_back(want);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got = {out_mon_i.read_data, out_mon_i.level_a, out_mon_i.level_b,
               out_mon_i.level_c, out_mon_i.level_sum};
        if (expected_levels_q.size() == 0) begin
          report("beat with nothing expected, read_data", 0, got.read_data);
        end else begin
          want = expected_levels_q.pop_front();
          if (got.read_data !== want.read_data) report("read_data", want.read_data, got.read_data);
          if (got.level_a !== want.level_a)     report("level_a", want.level_a, got.level_a);
          if (got.level_b !== want.level_b)     report("level_b", want.level_b, got.level_b);
          if (got.level_c !== want.level_c)     report("level_c", want.level_c, got.level_c);
          if (got.level_sum !== want.level_sum) report("level_sum", want.level_sum, got.level_sum);
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_levels_q.size();
    end
  end

endmodule

// ===== tb/sv/psg_tone_noise_envelope_top_test.sv =====
// stimulus and verdict for the sound generator, with the checker beside the block
module psg_tone_noise_envelope_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psg_pkg::*;

  // fine tone period registers have no names in the package
  localparam logic [RegAddrW-1:0] RegToneAFine = 4'd0;
  localparam logic [RegAddrW-1:0] RegToneBFine = 4'd2;
  localparam logic [RegAddrW-1:0] RegToneCFine = 4'd4;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;

  // idle-free stretches on each side, toggled now and then
  bit src_calm;
  bit sink_calm;

  psg_in_if  in_if ();
  psg_out_if out_if ();

  psg_tone_noise_envelope_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  psg_level_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // offer one input beat at a falling edge after a random gap, hold it until taken
  task automatic send_beat(input mode_e m, input logic [DataW-1:0] d,
                           input logic [DataW-1:0] cols, input logic [DataW-1:0] ext);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= m;
    in_if.data        <= d;
    in_if.key_columns <= cols;
    in_if.ext_lines   <= ext;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // bus beat with random keyboard and external lines
  task automatic bus_op(input mode_e m, input logic [DataW-1:0] d);
    send_beat(m, d, DataW'($urandom), DataW'($urandom));
  endtask

  // result side: random stall before each beat, then wait for it
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned      random_beats;
    int unsigned      pick;
    int unsigned      burst;
    logic [RegAddrW-1:0] reg_sel;
    logic [DataW-1:0] val;

    in_if.valid       = 1'b0;
    in_if.mode        = ModeTick;
    in_if.data        = '0;
    in_if.key_columns = '0;
    in_if.ext_lines   = '0;
    rst_ni            = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // port A as input: keys ANDed with the external lines
    bus_op(ModeLatch, {4'h0, RegPortA});
    send_beat(ModeRead, 8'h00, 8'hF0, 8'h3C);
    send_beat(ModeRead, 8'h00, 8'hFF, 8'hFF);
    // upper latch bits are ignored; port B as input reads all ones
    bus_op(ModeLatch, {4'hF, RegPortB});
    bus_op(ModeRead, 8'h00);
    // both ports as outputs, tones and noise all switched off
    bus_op(ModeLatch, {4'h0, RegMixer});
    bus_op(ModeWrite, 8'hFF);
    bus_op(ModeLatch, {4'hA, RegPortA});
    bus_op(ModeWrite, 8'hA5);
    bus_op(ModeRead, 8'h00);
    bus_op(ModeLatch, {4'h0, RegPortB});
    bus_op(ModeWrite, 8'h5A);
    bus_op(ModeRead, 8'h00);
    // unused bits of a coarse period read back as zero
    bus_op(ModeLatch, {4'h0, RegToneACoarse});
    bus_op(ModeWrite, 8'hFF);
    bus_op(ModeRead, 8'h00);
    // channel A follows the envelope, shape write restarts it
    bus_op(ModeLatch, {4'h0, RegAmpA});
    bus_op(ModeWrite, 8'hFF);
    bus_op(ModeLatch, {4'h0, RegEnvShape});
    bus_op(ModeWrite, 8'hFF);
    bus_op(ModeLatch, {4'h0, RegAmpB});
    bus_op(ModeWrite, 8'h0F);
    // two ticks with zero periods on the remaining generators
    bus_op(ModeTick, 8'h00);
    bus_op(ModeTick, 8'h00);

    // random part: mostly tick bursts and latch-then-write pairs, some reads and noise
    random_beats = 0;
    while (random_beats < 900) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        burst = $urandom_range(1, 24);
        repeat (burst) bus_op(ModeTick, DataW'($urandom));
        random_beats += burst;
      end else if (pick < 80) begin
        reg_sel = RegAddrW'($urandom_range(0, 15));
        // short periods keep tones, noise and envelope moving within the run
        case (reg_sel)
          RegToneAFine, RegToneBFine, RegToneCFine:
            val = ($urandom_range(0, 9) < 7) ? DataW'($urandom_range(0, 6))
                                             : DataW'($urandom);
          RegToneACoarse, RegToneBCoarse, RegToneCCoarse:
            val = ($urandom_range(0, 9) < 8) ? '0 : DataW'($urandom);
          RegNoisePeriod:
            val = ($urandom_range(0, 9) < 6) ? DataW'($urandom_range(0, 3))
                                             : DataW'($urandom);
          RegEnvPerLo:
            val = ($urandom_range(0, 9) < 7) ? DataW'($urandom_range(0, 2))
                                             : DataW'($urandom);
          RegEnvPerHi:
            val = ($urandom_range(0, 9) < 9) ? '0 : DataW'($urandom);
          default:
            val = DataW'($urandom);
        endcase
        bus_op(ModeLatch, {4'($urandom), reg_sel});
        bus_op(ModeWrite, val);
        random_beats += 2;
      end else if (pick < 92) begin
        bus_op(ModeLatch, DataW'($urandom));
        bus_op(ModeRead, DataW'($urandom));
        random_beats += 2;
      end else begin
        // lone beat of any kind: write without a fresh latch, stray latch, etc.
        bus_op(mode_e'($urandom_range(0, 3)), DataW'($urandom));
        random_beats++;
      end
    end
    in_if.valid <= 1'b0;

    // drain, then allow for the output register
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/psg_pkg.sv
rtl/psg_in_if.sv
rtl/psg_out_if.sv
rtl/psg_tone_noise_envelope_top.sv
tb/sv/psg_level_checker.sv
tb/sv/psg_tone_noise_envelope_top_test.sv
